// ===== rtl/tlre_pkg.sv =====
package tlre_pkg;

    // fixed widths of the stream fields
    localparam int FIELD_W   = 16;
    localparam int S_TDATA_W = 32;
    localparam int SUM_W     = 32;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    typedef enum logic [2:0] {
        E_IDLE,
        E_SQX,
        E_SQY,
        E_SUM,
        E_ROOT,
        E_DONE
    } edge_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_EDGE1,
        T_EDGE2,
        T_EMIT
    } top_state_t;

endpackage

// ===== rtl/tour_length_rounded_euclid.sv =====
// Sums a closed tour with edges rounded to the nearest integer. Cities come in visiting
// order, one transfer each, tlast on the final city; that transfer yields one result
// carrying the total including the closing edge, saturated at all ones with the overflow
// flag in m_tuser. The first city of a tour is only stored; a one-city tour then loads its
// result. Every later city runs one edge through the digit-serial root unit, which retires
// one root bit per cycle; the last city adds a second, closing edge and then loads the
// result, later while the previous result waits. Coordinates above COORD_BITS bits are
// masked off.
module tour_length_rounded_euclid #(
    parameter int COORD_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tlre_pkg::S_TDATA_W-1:0]     s_tdata,  // x_coord, y_coord
    input  logic                               s_tlast,  // is_last
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tlre_pkg::M_TDATA_W-1:0]     m_tdata,  // tour_length
    output logic [tlre_pkg::M_TUSER_W-1:0]     m_tuser   // overflowed
);
    import tlre_pkg::*;

    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    top_state_t state_reg, state_next;

    logic [CW-1:0]    first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             sat_reg;
    logic             in_tour_reg;
    logic             last_reg;
    logic             m_tvalid_reg;
    logic [SUM_W-1:0] m_sum_reg;
    logic             m_ovf_reg;

    logic [CW-1:0]    in_x, in_y;
    logic [CW-1:0]    bx, by;
    logic             accept;
    logic             edge_start;
    logic             edge_done;
    logic [CW:0]      edge_dist;
    logic             load;
    logic [SUM_W:0]   sum_add;

    assign in_x   = s_tdata[CW-1:0];
    assign in_y   = s_tdata[FIELD_W +: CW];
    assign accept = s_tvalid && s_tready;

    // new city against the previous one, then the closing edge against the first
    assign bx = (state_reg == T_IDLE) ? in_x : first_x_reg;
    assign by = (state_reg == T_IDLE) ? in_y : first_y_reg;

    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(edge_dist);

    tlre_edge #(
        .CW (CW)
    ) u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (edge_start),
        .ax      (prev_x_reg),
        .ay      (prev_y_reg),
        .bx      (bx),
        .by      (by),
        .done    (edge_done),
        .seg_len (edge_dist)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        edge_start = 1'b0;
        load       = 1'b0;
        case (state_reg)
            T_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_tour_reg) begin
                        edge_start = 1'b1;
                        state_next = T_EDGE1;
                    end else if (s_tlast) begin
                        // single city: closing edge is zero
                        state_next = T_EMIT;
                    end
                end
            end
            T_EDGE1: begin
                if (edge_done) begin
                    if (last_reg) begin
                        edge_start = 1'b1;
                        state_next = T_EDGE2;
                    end else begin
                        state_next = T_IDLE;
                    end
                end
            end
            T_EDGE2: begin
                if (edge_done) state_next = T_EMIT;
            end
            T_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    load       = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_tour_reg  <= 1'b0;
            sum_reg      <= '0;
            sat_reg      <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                prev_x_reg <= in_x;
                prev_y_reg <= in_y;
                last_reg   <= s_tlast;
                if (!in_tour_reg) begin
                    first_x_reg <= in_x;
                    first_y_reg <= in_y;
                    in_tour_reg <= 1'b1;
                end
            end
            if (edge_done && (state_reg == T_EDGE1 || state_reg == T_EDGE2)) begin
                if (sum_add[SUM_W]) begin
                    sum_reg <= '1;
                    sat_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_add[SUM_W-1:0];
                end
            end
            if (load) begin
                in_tour_reg <= 1'b0;
                sum_reg     <= '0;
                sat_reg     <= 1'b0;
                prev_x_reg  <= '0;
                prev_y_reg  <= '0;
                first_x_reg <= '0;
                first_y_reg <= '0;
                last_reg    <= 1'b0;
            end
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_sum_reg <= sum_reg;
            m_ovf_reg <= sat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_sum_reg;
    assign m_tuser  = M_TUSER_W'(m_ovf_reg);

`ifndef SYNTHESIS
    a_done_in_edge_state: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_done |-> (state_reg == T_EDGE1 || state_reg == T_EDGE2))
        else $error("edge unit finished while no edge was pending");

    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg |-> (sum_reg == '1))
        else $error("saturation flag set but sum not clamped");

    a_out_flag_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '1))
        else $error("overflow reported with a sum below maximum");

    a_edge_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_EDGE1 || state_reg == T_EDGE2) |-> !s_tready)
        else $error("input taken while an edge is in flight");
`endif

endmodule

// ===== rtl/tlre_edge.sv =====
module tlre_edge #(
    parameter int CW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [CW-1:0] ax,
    input  logic [CW-1:0] ay,
    input  logic [CW-1:0] bx,
    input  logic [CW-1:0] by,
    output logic          done,
    output logic [CW:0]   seg_len
);
    import tlre_pkg::*;

    localparam int RW    = CW + 1;
    localparam int RAD_W = 2 * RW;
    localparam int REM_W = RW + 2;
    localparam int SH_W  = REM_W + 2;
    localparam int CNT_W = $clog2(RW);

    edge_state_t state_reg, state_next;

    logic [CW-1:0]    dx_reg, dy_reg;
    logic [2*CW-1:0]  prod_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [RW-1:0]    root_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             ready;
    logic [SH_W-1:0]  rem_sh;
    logic [SH_W-1:0]  trial;
    logic             fits;

    assign ready  = (state_reg == E_IDLE) || (state_reg == E_DONE);
    // bring down the next two radicand bits
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = SH_W'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE: begin
                if (start) state_next = E_SQX;
            end
            E_SQX:  state_next = E_SQY;
            E_SQY:  state_next = E_SUM;
            E_SUM:  state_next = E_ROOT;
            E_ROOT: begin
                if (cnt_reg == '0) state_next = E_DONE;
            end
            E_DONE: begin
                state_next = start ? E_SQX : E_IDLE;
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ready && start) begin
            dx_reg <= (ax >= bx) ? ax - bx : bx - ax;
            dy_reg <= (ay >= by) ? ay - by : by - ay;
        end
        case (state_reg)
            E_SQX: begin
                prod_reg <= dx_reg * dx_reg;
            end
            E_SQY: begin
                prod_reg <= dy_reg * dy_reg;
                rad_reg  <= RAD_W'(prod_reg);
            end
            E_SUM: begin
                rad_reg  <= rad_reg + RAD_W'(prod_reg);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(RW - 1);
            end
            E_ROOT: begin
                // one root bit per cycle, restoring
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                cnt_reg <= cnt_reg - 1'b1;
                if (fits) begin
                    rem_reg  <= REM_W'(rem_sh - trial);
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    rem_reg  <= REM_W'(rem_sh);
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // round to nearest: remainder above the root means the next integer is closer
    assign done    = (state_reg == E_DONE);
    assign seg_len = (rem_reg > REM_W'(root_reg)) ? root_reg + 1'b1 : root_reg;

endmodule

// ===== dv/tour_length_rounded_euclid_sb.sv =====
package tour_length_sb_pkg;

    import tlre_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic             clamped;
    } tour_total_t;

    class tour_scoreboard;

        logic [FIELD_W-1:0] start_x, start_y, last_x, last_y;
        logic [SUM_W-1:0]   running_len;
        logic               clamped;
        logic               open_tour;
        tour_total_t        pending_totals[$];
        int                 errors;
        int                 totals_seen;

        function new();
            errors = 0;
            totals_seen = 0;
            clear_tour();
        endfunction

        function void clear_tour();
            start_x = '0;
            start_y = '0;
            last_x = '0;
            last_y = '0;
            running_len = '0;
            clamped = 1'b0;
            open_tour = 1'b0;
        endfunction

        // nearest integer to the euclidean distance, exact integer arithmetic
        function logic [FIELD_W:0] rounded_dist(logic [FIELD_W-1:0] ax, logic [FIELD_W-1:0] ay,
                                                logic [FIELD_W-1:0] bx, logic [FIELD_W-1:0] by);
            longint unsigned dx, dy, s, r, trial;
            dx = (ax >= bx) ? ax - bx : bx - ax;
            dy = (ay >= by) ? ay - by : by - ay;
            s = dx * dx + dy * dy;
            r = 0;
            for (int i = FIELD_W; i >= 0; i--) begin
                trial = r | (64'd1 << i);
                if (trial * trial <= s)
                    r = trial;
            end
            if (s - r * r > r)
                r = r + 1;
            return r[FIELD_W:0];
        endfunction

        function void add_leg(logic [FIELD_W-1:0] ax, logic [FIELD_W-1:0] ay,
                              logic [FIELD_W-1:0] bx, logic [FIELD_W-1:0] by);
            logic [SUM_W:0] t;
            t = running_len + rounded_dist(ax, ay, bx, by);
            if (t[SUM_W]) begin
                running_len = '1;
                clamped = 1'b1;
            end else begin
                running_len = t[SUM_W-1:0];
            end
        endfunction

        function void note_city(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic is_last);
            tour_total_t t;
            if (!open_tour) begin
                start_x = x;
                start_y = y;
                running_len = '0;
                clamped = 1'b0;
                open_tour = 1'b1;
            end else begin
                add_leg(last_x, last_y, x, y);
            end
            last_x = x;
            last_y = y;
            if (is_last) begin
                add_leg(x, y, start_x, start_y);
                t.total = running_len;
                t.clamped = clamped;
                pending_totals = {pending_totals, t};
                clear_tour();
            end
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_total(logic [SUM_W-1:0] got_total, logic got_clamped);
            tour_total_t want;
            totals_seen++;
            if (pending_totals.size() == 0) begin
                flag_error($sformatf("total #%0d not expected: length %0d overflowed %0b",
                                     totals_seen, got_total, got_clamped));
                return;
            end
            want = pending_totals.pop_front();
            if (got_total !== want.total)
                flag_error($sformatf("total #%0d length: expected %0d, got %0d",
                                     totals_seen, want.total, got_total));
            if (got_clamped !== want.clamped)
                flag_error($sformatf("total #%0d overflowed: expected %0b, got %0b",
                                     totals_seen, want.clamped, got_clamped));
        endfunction

        function int pending();
            return pending_totals.size();
        endfunction

    endclass

endpackage

// ===== dv/tour_length_rounded_euclid_tb.sv =====
module tour_length_rounded_euclid_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tlre_pkg::*;
    import tour_length_sb_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int CITY_TARGET = 1200;
    // worst per city: long input gap, own and closing edge, long output stall
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    tour_scoreboard tour_sb;
    bit             no_idle = 1'b0;
    int             cities_sent = 0;
    int             cycles_run = 0;

    tour_length_rounded_euclid #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return FIELD_W'($urandom_range(0, 15));
            4:       return FIELD_W'(16'hFFFF - $urandom_range(0, 15));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic push_city(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tour_sb.note_city(x, y, is_last);
        cities_sent++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (tour_sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic directed_tours();
        // one-city tours at both corners
        push_city(16'h0000, 16'h0000, 1'b1);
        push_city(16'hFFFF, 16'hFFFF, 1'b1);
        // longest edge, both ways
        push_city(16'h0000, 16'h0000, 1'b0);
        push_city(16'hFFFF, 16'hFFFF, 1'b1);
        // 3-4-5 triangle
        push_city(16'd0, 16'd0, 1'b0);
        push_city(16'd3, 16'd4, 1'b0);
        push_city(16'd0, 16'd4, 1'b1);
        // rounding down and up: sqrt 2, sqrt 5, sqrt 8, sqrt 41
        push_city(16'd100, 16'd100, 1'b0);
        push_city(16'd101, 16'd101, 1'b0);
        push_city(16'd102, 16'd103, 1'b0);
        push_city(16'd104, 16'd105, 1'b1);
        // repeated city gives a zero edge, alternating bit patterns
        push_city(16'hAAAA, 16'h5555, 1'b0);
        push_city(16'hAAAA, 16'h5555, 1'b0);
        push_city(16'h5555, 16'hAAAA, 1'b1);
        // mixed corners
        push_city(16'h0000, 16'hFFFF, 1'b0);
        push_city(16'hFFFF, 16'h0000, 1'b0);
        push_city(16'hFFFF, 16'hFFFF, 1'b0);
        push_city(16'h0000, 16'h0000, 1'b1);
    endtask

    task automatic random_tours();
        int                 n_cities;
        int                 r;
        logic [FIELD_W-1:0] x, y;
        x = '0;
        y = '0;
        while (cities_sent < CITY_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                n_cities = 1;
            else if (r < 90)
                n_cities = $urandom_range(2, 6);
            else
                n_cities = $urandom_range(7, 40);
            no_idle = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < n_cities; i++) begin
                if (i == 0 || $urandom_range(0, 15) != 0) begin
                    x = pick_coord();
                    y = pick_coord();
                end
                push_city(x, y, i == n_cities - 1);
            end
            if ($urandom_range(0, 39) == 0)
                wait_for_drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        tour_sb  = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_tours();
        // sender holds off until every total is back
        wait_for_drain();
        random_tours();

        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (64) @(posedge aclk);
        if (tour_sb.errors == 0)
            $display("tour_length_rounded_euclid_tb: clean");
        else
            $display("tour_length_rounded_euclid_tb: errors");
        $finish;
    end

    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tour_sb.check_total(m_tdata, m_tuser[0]);
    end

    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("tour_length_rounded_euclid_tb: errors");
        $finish;
    end

endmodule
